// ----- design/mqrf_pkg.sv -----
package mqrf_pkg;

  localparam int NUM_QUEUES_DEF = 4;
  localparam int MAX_DEPTH_DEF  = 64;
  localparam int ITEM_BYTES_DEF = 4;

  localparam int OP_W     = 2;
  localparam int QID_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_GET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOSS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_BYTE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_ENABLE = 2'd3;

  localparam logic [6:0] CAPACITY_RST     = 7'd64;
  localparam logic [3:0] QUEUE_ENABLE_RST = 4'hF;

  typedef struct packed {
    logic load;
    logic exec;
    logic take_rd;
  } mqrf_cmd_t;

  typedef struct packed {
    logic rd_pend;
  } mqrf_sts_t;

endpackage

// ----- design/mqrf_ctrl.sv -----
module mqrf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  mqrf_pkg::mqrf_sts_t sts,
  output mqrf_pkg::mqrf_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = sts.rd_pend ? S_READ : S_OUT;
      end
      S_READ: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall    = (state != S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign cmd.load    = (state == S_IDLE) && in_valid;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.take_rd = (state == S_READ);

endmodule

// ----- design/mqrf_dp.sv -----
module mqrf_dp #(
  parameter int NUM_QUEUES = mqrf_pkg::NUM_QUEUES_DEF,
  parameter int MAX_DEPTH  = mqrf_pkg::MAX_DEPTH_DEF,
  parameter int ITEM_BYTES = mqrf_pkg::ITEM_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mqrf_pkg::mqrf_cmd_t                 cmd,
  output mqrf_pkg::mqrf_sts_t                 sts,
  input  logic                                cfg_we,
  input  logic [mqrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mqrf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [mqrf_pkg::OP_W-1:0]           op,
  input  logic [mqrf_pkg::QID_W-1:0]          queue_id,
  input  logic [mqrf_pkg::DATA_W-1:0]         data_in,
  output logic [mqrf_pkg::STATUS_W-1:0]       status,
  output logic [mqrf_pkg::DATA_W-1:0]         data_out,
  output logic [mqrf_pkg::COUNT_W-1:0]        item_count
);

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int IW    = $clog2(MAX_DEPTH);
  localparam int OW    = $clog2(MAX_DEPTH + 1);
  localparam int DEPTH = NUM_QUEUES * MAX_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KB    = (ITEM_BYTES < 4) ? ITEM_BYTES : 4;
  localparam int DW    = 8 * KB;

  // configuration
  logic [6:0] capacity;
  logic       overwrite_enable;
  logic [7:0] fill_byte;
  logic [3:0] queue_enable;

  // latched item
  logic [mqrf_pkg::OP_W-1:0]  op_r;
  logic [mqrf_pkg::QID_W-1:0] qid_r;
  logic [DW-1:0]              din_r;

  // per-queue state
  logic [IW-1:0] rd_idx [NUM_QUEUES];
  logic [IW-1:0] wr_idx [NUM_QUEUES];
  logic [OW-1:0] occ    [NUM_QUEUES];

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_rdata;

  logic [QW-1:0] qsel;
  logic          q_ok;
  logic [OW-1:0] cap_eff;
  logic [DW-1:0] fill_pat;
  logic [3:0]    en_rise;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  logic [IW-1:0] cur_rd, cur_wr, new_rd, new_wr;
  logic [OW-1:0] cur_occ, new_occ;
  logic [mqrf_pkg::STATUS_W-1:0] st;
  logic [DW-1:0] dout;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;

  function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx, input logic [OW-1:0] cap);
    logic [OW:0] n;
    n = {{(OW + 1 - IW){1'b0}}, idx} + 1'b1;
    return (n >= {1'b0, cap}) ? '0 : IW'(n);
  endfunction

  assign qsel     = QW'(qid_r);
  assign fill_pat = {KB{fill_byte}};
  assign en_rise  = cfg_data[3:0] & ~queue_enable;

  always_comb begin
    priority if (capacity == 7'd0) begin
      cap_eff = OW'(1);
    end else if (32'(capacity) > MAX_DEPTH) begin
      cap_eff = OW'(MAX_DEPTH);
    end else begin
      cap_eff = OW'(capacity);
    end
  end

  always_comb begin
    q_ok      = (32'(qid_r) < NUM_QUEUES) && queue_enable[qid_r];
    cur_rd    = rd_idx[qsel];
    cur_wr    = wr_idx[qsel];
    cur_occ   = occ[qsel];
    rd_addr   = AW'(32'(qsel) * MAX_DEPTH + 32'(cur_rd));
    wr_addr   = AW'(32'(qsel) * MAX_DEPTH + 32'(cur_wr));
    new_rd    = cur_rd;
    new_wr    = cur_wr;
    new_occ   = cur_occ;
    st        = mqrf_pkg::ST_OK;
    dout      = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = din_r;
    if (!q_ok) begin
      st = mqrf_pkg::ST_INVALID;
    end else begin
      unique case (op_r)
        mqrf_pkg::OP_PUT: begin
          if (cur_occ < cap_eff) begin
            mem_we  = 1'b1;
            new_wr  = adv(cur_wr, cap_eff);
            new_occ = cur_occ + 1'b1;
          end else if (overwrite_enable) begin
            mem_we = 1'b1;
            new_wr = adv(cur_wr, cap_eff);
            new_rd = adv(cur_rd, cap_eff);
            st     = mqrf_pkg::ST_LOSS;
          end else begin
            st = mqrf_pkg::ST_FULL;
          end
        end
        mqrf_pkg::OP_GET: begin
          if (cur_occ != '0) begin
            // read-first port: old item comes out, slot gets the fill pattern
            mem_re    = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = rd_addr;
            mem_wdata = fill_pat;
            new_rd    = adv(cur_rd, cap_eff);
            new_occ   = cur_occ - 1'b1;
          end else begin
            dout = fill_pat;
            st   = mqrf_pkg::ST_EMPTY;
          end
        end
        mqrf_pkg::OP_CLEAR: begin
          new_rd  = '0;
          new_wr  = '0;
          new_occ = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.rd_pend = mem_re;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op;
      qid_r <= queue_id;
      din_r <= DW'(data_in);
    end
    if (cmd.exec) begin
      status     <= st;
      data_out   <= 32'(dout);
      item_count <= q_ok ? mqrf_pkg::COUNT_W'(new_occ) : '0;
    end
    if (cmd.take_rd) begin
      data_out <= 32'(mem_rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_re) begin
      mem_rdata <= mem[rd_addr];
    end
    if (cmd.exec && mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity         <= mqrf_pkg::CAPACITY_RST;
      overwrite_enable <= 1'b0;
      fill_byte        <= '0;
      queue_enable     <= mqrf_pkg::QUEUE_ENABLE_RST;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_idx[i] <= '0;
        wr_idx[i] <= '0;
        occ[i]    <= '0;
      end
    end else begin
      if (cmd.exec && q_ok) begin
        rd_idx[qsel] <= new_rd;
        wr_idx[qsel] <= new_wr;
        occ[qsel]    <= new_occ;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          mqrf_pkg::CFG_CAPACITY:  capacity <= cfg_data[6:0];
          mqrf_pkg::CFG_OVERWRITE: overwrite_enable <= cfg_data[0];
          mqrf_pkg::CFG_FILL_BYTE: fill_byte <= cfg_data;
          mqrf_pkg::CFG_QUEUE_ENABLE: begin
            queue_enable <= cfg_data[3:0];
            // a queue that comes back on starts empty
            for (int i = 0; i < NUM_QUEUES; i++) begin
              if (i < 4) begin
                if (en_rise[i[1:0]]) begin
                  rd_idx[i] <= '0;
                  wr_idx[i] <= '0;
                  occ[i]    <= '0;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- design/multi_queue_ring_fifo_core.sv -----
// flow: the item is latched at the input transfer, executed in the exec state
// and presented in the out state; a get that reads the item store also passes
// the read state (one registered read port); one item is in flight at a time,
// as in_stall holds off the next input until the result has transferred
// reset: synchronous rst empties every queue and restores the registers to
// capacity 64, no overwrite, fill byte 0, all queues on; store contents undefined
module multi_queue_ring_fifo_core #(
  parameter int NUM_QUEUES = mqrf_pkg::NUM_QUEUES_DEF,
  parameter int MAX_DEPTH  = mqrf_pkg::MAX_DEPTH_DEF,
  parameter int ITEM_BYTES = mqrf_pkg::ITEM_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mqrf_pkg::OP_W-1:0]        op,
  input  logic [mqrf_pkg::QID_W-1:0]       queue_id,
  input  logic [mqrf_pkg::DATA_W-1:0]      data_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mqrf_pkg::STATUS_W-1:0]    status,
  output logic [mqrf_pkg::DATA_W-1:0]      data_out,
  output logic [mqrf_pkg::COUNT_W-1:0]     item_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mqrf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mqrf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mqrf_pkg::mqrf_cmd_t cmd;
  mqrf_pkg::mqrf_sts_t sts;

  assign cfg_ready = 1'b1;

  mqrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mqrf_dp #(
    .NUM_QUEUES (NUM_QUEUES),
    .MAX_DEPTH  (MAX_DEPTH),
    .ITEM_BYTES (ITEM_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .queue_id   (queue_id),
    .data_in    (data_in),
    .status     (status),
    .data_out   (data_out),
    .item_count (item_count)
  );

endmodule

// ----- dv/multi_queue_ring_fifo_core_tb.sv -----
module multi_queue_ring_fifo_core_tb;

  localparam int NQ    = mqrf_pkg::NUM_QUEUES_DEF;
  localparam int DEPTH = mqrf_pkg::MAX_DEPTH_DEF;
  localparam logic [mqrf_pkg::OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [mqrf_pkg::STATUS_W-1:0] status;
    logic [mqrf_pkg::DATA_W-1:0]   data;
    logic [mqrf_pkg::COUNT_W-1:0]  count;
  } fifo_result_t;

  typedef struct {
    bit                              is_reg;
    logic [mqrf_pkg::CFG_IDX_W-1:0]  idx;
    logic [mqrf_pkg::CFG_DATA_W-1:0] val;
    logic [mqrf_pkg::OP_W-1:0]       o;
    logic [mqrf_pkg::QID_W-1:0]      q;
    logic [mqrf_pkg::DATA_W-1:0]     d;
    bit                              typed;
    fifo_result_t                    want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [mqrf_pkg::OP_W-1:0] op = '0;
  logic [mqrf_pkg::QID_W-1:0] queue_id = '0;
  logic [mqrf_pkg::DATA_W-1:0] data_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [mqrf_pkg::STATUS_W-1:0] status;
  logic [mqrf_pkg::DATA_W-1:0] data_out;
  logic [mqrf_pkg::COUNT_W-1:0] item_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mqrf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mqrf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  multi_queue_ring_fifo_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .queue_id(queue_id), .data_in(data_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .data_out(data_out), .item_count(item_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the queues and registers
  logic [6:0] cap_reg;
  logic ovw_reg;
  logic [7:0] fill_reg;
  logic [3:0] qen_reg;
  int unsigned rd_ptr[NQ];
  int unsigned wr_ptr[NQ];
  int unsigned fill_level[NQ];
  logic [mqrf_pkg::DATA_W-1:0] store_mem[NQ*DEPTH];
  bit store_valid[NQ*DEPTH];

  fifo_result_t pending_results[$];
  bit row_typed = 1'b0;
  fifo_result_t row_want = '0;
  int err_count = 0;
  dir_row_t dir_rows[$];
  int burst_left = 0;

  function automatic int unsigned eff_cap();
    int unsigned c;
    c = 32'(cap_reg);
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic int unsigned next_ptr(int unsigned idx);
    int unsigned n;
    n = idx + 1;
    return (n >= eff_cap()) ? 0 : n;
  endfunction

  function automatic int unsigned slot_of(int unsigned q, int unsigned idx);
    return q * DEPTH + idx % DEPTH;
  endfunction

  function automatic void clear_queue(int unsigned q);
    rd_ptr[q] = 0;
    wr_ptr[q] = 0;
    fill_level[q] = 0;
  endfunction

  function automatic void apply_reg_write(logic [mqrf_pkg::CFG_IDX_W-1:0] idx,
                                          logic [mqrf_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      mqrf_pkg::CFG_CAPACITY: cap_reg = v[6:0];
      mqrf_pkg::CFG_OVERWRITE: ovw_reg = v[0];
      mqrf_pkg::CFG_FILL_BYTE: fill_reg = v;
      mqrf_pkg::CFG_QUEUE_ENABLE: begin
        // a queue coming back on starts out empty
        for (int q = 0; q < NQ; q++)
          if (v[q] && !qen_reg[q]) clear_queue(q);
        qen_reg = v[3:0];
      end
      default: ;
    endcase
  endfunction

  function automatic fifo_result_t apply_queue_op(logic [mqrf_pkg::OP_W-1:0] o,
                                                  logic [mqrf_pkg::QID_W-1:0] q,
                                                  logic [mqrf_pkg::DATA_W-1:0] d);
    fifo_result_t r;
    int unsigned s;
    r = '{mqrf_pkg::ST_OK, '0, '0};
    if (!qen_reg[q]) begin
      r.status = mqrf_pkg::ST_INVALID;
      return r;
    end
    case (o)
      mqrf_pkg::OP_PUT: begin
        if (fill_level[q] < eff_cap() || ovw_reg) begin
          s = slot_of(32'(q), wr_ptr[q]);
          store_mem[s] = d;
          store_valid[s] = 1'b1;
          wr_ptr[q] = next_ptr(wr_ptr[q]);
          if (fill_level[q] < eff_cap()) begin
            fill_level[q]++;
          end else begin
            // oldest item dropped, count stays
            rd_ptr[q] = next_ptr(rd_ptr[q]);
            r.status = mqrf_pkg::ST_LOSS;
          end
        end else begin
          r.status = mqrf_pkg::ST_FULL;
        end
      end
      mqrf_pkg::OP_GET: begin
        if (fill_level[q] != 0) begin
          s = slot_of(32'(q), rd_ptr[q]);
          r.data = store_mem[s];
          store_mem[s] = {4{fill_reg}};
          rd_ptr[q] = next_ptr(rd_ptr[q]);
          fill_level[q]--;
        end else begin
          r.data = {4{fill_reg}};
          r.status = mqrf_pkg::ST_EMPTY;
        end
      end
      mqrf_pkg::OP_CLEAR: clear_queue(32'(q));
      default: ;
    endcase
    r.count = mqrf_pkg::COUNT_W'(fill_level[q]);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [mqrf_pkg::DATA_W-1:0] got,
                                 logic [mqrf_pkg::DATA_W-1:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $time, field, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin : monitor
    fifo_result_t want;
    if (rst) begin
      cap_reg = mqrf_pkg::CAPACITY_RST;
      ovw_reg = 1'b0;
      fill_reg = '0;
      qen_reg = mqrf_pkg::QUEUE_ENABLE_RST;
      for (int q = 0; q < NQ; q++) clear_queue(q);
      for (int i = 0; i < NQ * DEPTH; i++) store_valid[i] = 1'b0;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result status", mqrf_pkg::DATA_W'(status), '0);
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            report_mismatch("status", mqrf_pkg::DATA_W'(status),
                            mqrf_pkg::DATA_W'(want.status));
          if (data_out !== want.data) report_mismatch("data_out", data_out, want.data);
          if (item_count !== want.count)
            report_mismatch("item_count", mqrf_pkg::DATA_W'(item_count),
                            mqrf_pkg::DATA_W'(want.count));
        end
      end
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        want = apply_queue_op(op, queue_id, data_in);
        pending_results.push_back(row_typed ? row_want : want);
      end
    end
  end

  // receiver back-pressure, switching pattern every so often
  int stall_mode = 0;
  int stall_cyc = 0;
  always @(negedge clk) begin
    stall_cyc++;
    if (stall_cyc % 150 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 3) == 0);
      2: out_stall = (stall_cyc % 16) < 9;
      default: out_stall = 1'($urandom_range(0, 1));
    endcase
  end

  task automatic send_item(logic [mqrf_pkg::OP_W-1:0] o, logic [mqrf_pkg::QID_W-1:0] q,
                           logic [mqrf_pkg::DATA_W-1:0] d, bit typed, fifo_result_t w);
    in_valid = 1'b1;
    op = o;
    queue_id = q;
    data_in = d;
    row_typed = typed;
    row_want = w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [mqrf_pkg::CFG_IDX_W-1:0] idx,
                           logic [mqrf_pkg::CFG_DATA_W-1:0] v);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_reg(logic [mqrf_pkg::CFG_IDX_W-1:0] idx,
                         logic [mqrf_pkg::CFG_DATA_W-1:0] v);
    dir_row_t r;
    r = '{1'b1, idx, v, mqrf_pkg::OP_PUT, '0, '0, 1'b0, '0};
    dir_rows.push_back(r);
  endtask

  task automatic add_item(logic [mqrf_pkg::OP_W-1:0] o, logic [mqrf_pkg::QID_W-1:0] q,
                          logic [mqrf_pkg::DATA_W-1:0] d);
    dir_row_t r;
    r = '{1'b0, mqrf_pkg::CFG_CAPACITY, '0, o, q, d, 1'b0, '0};
    dir_rows.push_back(r);
  endtask

  task automatic add_typed(logic [mqrf_pkg::OP_W-1:0] o, logic [mqrf_pkg::QID_W-1:0] q,
                           logic [mqrf_pkg::DATA_W-1:0] d,
                           logic [mqrf_pkg::STATUS_W-1:0] st,
                           logic [mqrf_pkg::DATA_W-1:0] dout,
                           logic [mqrf_pkg::COUNT_W-1:0] cnt);
    dir_row_t r;
    r = '{1'b0, mqrf_pkg::CFG_CAPACITY, '0, o, q, d, 1'b1, '{st, dout, cnt}};
    dir_rows.push_back(r);
  endtask

  // bursts of transfers separated by random gaps, some of them zero
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic random_item(int put_pct, logic [mqrf_pkg::QID_W-1:0] focus);
    logic [mqrf_pkg::OP_W-1:0] o;
    logic [mqrf_pkg::QID_W-1:0] q;
    logic [mqrf_pkg::DATA_W-1:0] d;
    int r;
    r = $urandom_range(0, 99);
    q = $urandom_range(0, 1) ? focus : mqrf_pkg::QID_W'($urandom_range(0, 3));
    if (r < 3) o = OP_NONE;
    else if (r < 8) o = mqrf_pkg::OP_CLEAR;
    else if (r < 8 + put_pct * 92 / 100) o = mqrf_pkg::OP_PUT;
    else o = mqrf_pkg::OP_GET;
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = '1;
      default: d = $urandom;
    endcase
    // never read a slot that was never written
    if (o == mqrf_pkg::OP_GET && qen_reg[q] && fill_level[q] != 0 &&
        !store_valid[slot_of(32'(q), rd_ptr[q])]) o = mqrf_pkg::OP_PUT;
    send_item(o, q, d, 1'b0, '0);
  endtask

  int ph_cap[8] = '{4, 4, 0, 127, 2, 100, -1, 64};
  int ph_ovw[8] = '{0, 1, 1, 0, 1, 1, -1, 0};
  int ph_fill[8] = '{0, 255, 60, -1, -1, -1, -1, 0};
  int ph_qen[8] = '{15, 15, 0, 15, 6, 15, -1, 15};
  int ph_len[8] = '{120, 120, 20, 150, 120, 120, 140, 120};
  int pct_choice[4] = '{20, 50, 80, 95};

  initial begin
    int put_pct;
    logic [mqrf_pkg::QID_W-1:0] focus;

    // after reset: capacity 64, no overwrite, fill 0, all queues on
    add_typed(mqrf_pkg::OP_GET, 0, 32'h0, mqrf_pkg::ST_EMPTY, 32'h0, 0);
    add_typed(mqrf_pkg::OP_PUT, 0, 32'hFFFF_FFFF, mqrf_pkg::ST_OK, 32'h0, 1);
    add_typed(mqrf_pkg::OP_PUT, 0, 32'h0, mqrf_pkg::ST_OK, 32'h0, 2);
    add_typed(mqrf_pkg::OP_PUT, 1, 32'hA5A5_5A5A, mqrf_pkg::ST_OK, 32'h0, 1);
    add_typed(mqrf_pkg::OP_GET, 0, 32'h0, mqrf_pkg::ST_OK, 32'hFFFF_FFFF, 1);
    add_typed(mqrf_pkg::OP_GET, 0, 32'h0, mqrf_pkg::ST_OK, 32'h0, 0);
    add_typed(mqrf_pkg::OP_GET, 0, 32'h0, mqrf_pkg::ST_EMPTY, 32'h0, 0);
    add_typed(OP_NONE, 1, 32'h0, mqrf_pkg::ST_OK, 32'h0, 1);
    add_typed(mqrf_pkg::OP_CLEAR, 1, 32'h0, mqrf_pkg::ST_OK, 32'h0, 0);
    add_typed(mqrf_pkg::OP_GET, 1, 32'h0, mqrf_pkg::ST_EMPTY, 32'h0, 0);
    add_typed(mqrf_pkg::OP_PUT, 3, 32'h8000_0001, mqrf_pkg::ST_OK, 32'h0, 1);
    add_item(mqrf_pkg::OP_PUT, 2, 32'h1234_5678);
    add_typed(mqrf_pkg::OP_GET, 3, 32'h0, mqrf_pkg::ST_OK, 32'h8000_0001, 0);
    // one-deep queues with overwrite, fill all ones, queues 1 and 3 off
    add_reg(mqrf_pkg::CFG_CAPACITY, 8'd1);
    add_reg(mqrf_pkg::CFG_OVERWRITE, 8'd1);
    add_reg(mqrf_pkg::CFG_FILL_BYTE, 8'hFF);
    add_reg(mqrf_pkg::CFG_QUEUE_ENABLE, 8'h5);
    add_typed(mqrf_pkg::OP_PUT, 0, 32'hDEAD_BEEF, mqrf_pkg::ST_OK, 32'h0, 1);
    add_typed(mqrf_pkg::OP_PUT, 0, 32'h0BAD_F00D, mqrf_pkg::ST_LOSS, 32'h0, 1);
    add_typed(mqrf_pkg::OP_GET, 0, 32'h0, mqrf_pkg::ST_OK, 32'h0BAD_F00D, 0);
    add_typed(mqrf_pkg::OP_GET, 0, 32'h0, mqrf_pkg::ST_EMPTY, 32'hFFFF_FFFF, 0);
    add_typed(mqrf_pkg::OP_PUT, 1, 32'h1, mqrf_pkg::ST_INVALID, 32'h0, 0);
    add_typed(mqrf_pkg::OP_GET, 3, 32'h0, mqrf_pkg::ST_INVALID, 32'h0, 0);
    add_typed(OP_NONE, 1, 32'h0, mqrf_pkg::ST_INVALID, 32'h0, 0);
    add_item(mqrf_pkg::OP_PUT, 2, 32'h0000_0055);
    add_reg(mqrf_pkg::CFG_OVERWRITE, 8'd0);
    add_typed(mqrf_pkg::OP_PUT, 2, 32'h7777_7777, mqrf_pkg::ST_FULL, 32'h0, 1);
    add_item(mqrf_pkg::OP_GET, 2, 32'h0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        pace();
        send_item(dir_rows[i].o, dir_rows[i].q, dir_rows[i].d, dir_rows[i].typed,
                  dir_rows[i].want);
      end
    end

    for (int p = 0; p < 8; p++) begin
      write_reg(mqrf_pkg::CFG_CAPACITY, mqrf_pkg::CFG_DATA_W'(
                (ph_cap[p] < 0) ? $urandom_range(1, 8) : ph_cap[p]));
      write_reg(mqrf_pkg::CFG_OVERWRITE, mqrf_pkg::CFG_DATA_W'(
                (ph_ovw[p] < 0) ? $urandom_range(0, 1) : ph_ovw[p]));
      write_reg(mqrf_pkg::CFG_FILL_BYTE, mqrf_pkg::CFG_DATA_W'(
                (ph_fill[p] < 0) ? $urandom_range(0, 255) : ph_fill[p]));
      write_reg(mqrf_pkg::CFG_QUEUE_ENABLE, mqrf_pkg::CFG_DATA_W'(
                (ph_qen[p] < 0) ? $urandom_range(0, 15) : ph_qen[p]));
      put_pct = 50;
      focus = '0;
      for (int i = 0; i < ph_len[p]; i++) begin
        if (i % 30 == 0) begin
          put_pct = pct_choice[$urandom_range(0, 3)];
          focus = mqrf_pkg::QID_W'($urandom_range(0, 3));
        end
        pace();
        random_item(put_pct, focus);
      end
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
